>>> hw/rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg - shared types and constants for the scalar Kalman update core
// Gain format, sequencer counter width, register indexes and the control
// word of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Gain is unsigned Q0.16, one extra bit so that exactly one can be held
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // Step counter covers the GAIN_BITS+1 divide steps
  localparam int CNT_W = $clog2(GAIN_BITS + 1);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEAS_ERROR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_EST   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_ERR   = 2'd2;

  // Control of the shared unit: y = a + (inv ? ~b : b) + cin
  typedef struct packed {
    logic inv;
    logic cin;
  } skf_unit_ctl_t;

endpackage

>>> hw/rtl/skf_addsub.sv
// ----------------------------------------------------------------------------
// skf_addsub - shared add/subtract unit
// One wide adder with optional operand inversion and carry in. Serves the
// divide compare-subtract, the shift-add multiply and the state updates.
// ----------------------------------------------------------------------------
module skf_addsub #(
  parameter int W = 49
) (
  input  logic [W-1:0]          a,
  input  logic [W-1:0]          b,
  input  skf_pkg::skf_unit_ctl_t ctl,
  output logic [W-1:0]          y,
  output logic                  cout
);
  import skf_pkg::*;

  logic [W-1:0] b_sel;
  logic [W:0]   total;

  // Invert b for subtraction, carry in completes the two's complement
  assign b_sel = ctl.inv ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_sel} + {{W{1'b0}}, ctl.cin};
  assign y     = total[W-1:0];
  assign cout  = total[W];

endmodule

>>> hw/rtl/skf_cfg_regs.sv
// ----------------------------------------------------------------------------
// skf_cfg_regs - configuration register file
// Holds measurement error variance, initial estimate and initial error.
// Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module skf_cfg_regs #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-1:0]              cfg_data,
  output logic [DATA_WIDTH-1:0]              meas_error,
  output logic [DATA_WIDTH-1:0]              init_est,
  output logic [DATA_WIDTH-1:0]              init_err
);
  import skf_pkg::*;

  localparam logic [DATA_WIDTH-1:0] FIXED_ONE = DATA_WIDTH'(1) << FRAC_BITS;

  logic [DATA_WIDTH-1:0] meas_error_r, meas_error_nxt;
  logic [DATA_WIDTH-1:0] init_est_r, init_est_nxt;
  logic [DATA_WIDTH-1:0] init_err_r, init_err_nxt;

  // Always able to take a write
  assign cfg_ready = 1'b1;

  // Write decode
  always_comb begin
    meas_error_nxt = meas_error_r;
    init_est_nxt   = init_est_r;
    init_err_nxt   = init_err_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MEAS_ERROR: meas_error_nxt = cfg_data;
        CFG_INIT_EST:   init_est_nxt   = cfg_data;
        CFG_INIT_ERR:   init_err_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_error_r <= FIXED_ONE;
      init_est_r   <= '0;
      init_err_r   <= FIXED_ONE;
    end else begin
      meas_error_r <= meas_error_nxt;
      init_est_r   <= init_est_nxt;
      init_err_r   <= init_err_nxt;
    end
  end

  assign meas_error = meas_error_r;
  assign init_est   = init_est_r;
  assign init_err   = init_err_r;

endmodule

>>> hw/rtl/scalar_kalman_update_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_update_core - scalar Kalman filter measurement update
// Constant-state filter, no process noise. Per measurement:
//   gain = err / (err + meas_error), est += gain*(z - est), err *= (1 - gain)
// All filter arithmetic runs on one shared adder under a small sequencer.
//
//   channel | ports                               | flow control
//   --------+-------------------------------------+--------------------
//   in      | in_measurement, in_restart_first    | in_valid / in_stall
//   out     | out_gain, out_new_estimate, ...     | out_valid / out_stall
//   cfg     | cfg_index, cfg_data                 | cfg_valid / cfg_ready
//
// Sequence: a measurement runs the sum, 17 restoring divide steps and two
//   16-step shift-add multiplies on the shared adder into the result
//   register; the multiplies are skipped when the gain is zero or one, the
//   divide too on a zero denominator. A new measurement waits until the result is loaded.
// Reset: synchronous, active low; state returns to estimate 0, error one.
// Stalls: a pending result is held in the output register; the core keeps
//   working on the next transaction and waits only to hand over its result.
// ----------------------------------------------------------------------------
module scalar_kalman_update_core #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // measurement input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [DATA_WIDTH-1:0]      in_measurement,
  input  logic                              in_restart_first,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [skf_pkg::GAIN_W-1:0]        out_gain,
  output logic signed [DATA_WIDTH-1:0]      out_new_estimate,
  output logic [DATA_WIDTH-1:0]             out_new_error,
  output logic                              out_zero_denominator,
  // configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_data
);
  import skf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int W  = DW + GAIN_BITS + 1;   // holds the full product
  localparam logic [DW-1:0] FIXED_ONE = DW'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(GAIN_BITS);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_BITS - 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_GCHK = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_NEG  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_CORR = 4'd7;
  localparam logic [3:0] S_H    = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // Config registers
  logic [DW-1:0] meas_error, init_est, init_err;

  skf_cfg_regs #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .meas_error (meas_error),
    .init_est   (init_est),
    .init_err   (init_err)
  );

  // Control and datapath registers
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;   // 0: correction multiply, 1: error
  logic              neg_r, neg_nxt;
  logic              zero_r, zero_nxt;
  logic [DW-1:0]     z_r, z_nxt;
  logic [DW-1:0]     est_r, est_nxt;
  logic [DW-1:0]     err_r, err_nxt;
  logic [DW:0]       sum_r, sum_nxt;
  logic [DW+1:0]     rem_r, rem_nxt;
  logic [GAIN_W-1:0] q_r, q_nxt;
  logic [DW:0]       md_r, md_nxt;
  logic [GAIN_BITS-1:0] mr_r, mr_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0] out_gain_r;
  logic [DW-1:0]     out_est_r, out_err_r;
  logic              out_zero_r;
  logic              out_load;

  // Shared unit
  logic [W-1:0]  u_a, u_b, u_y;
  logic          u_cout;
  skf_unit_ctl_t u_ctl;
  logic [DW+1:0] div_a;

  skf_addsub #(.W(W)) u_unit (
    .a    (u_a),
    .b    (u_b),
    .ctl  (u_ctl),
    .y    (u_y),
    .cout (u_cout)
  );

  // First divide step compares err itself, later steps the doubled remainder
  assign div_a = (cnt_r == '0) ? rem_r : {rem_r[DW:0], 1'b0};

  // Operand selection for the shared unit
  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_ctl = '{inv: 1'b0, cin: 1'b0};
    case (state_r)
      S_SUM: begin
        u_a = W'(err_r);
        u_b = W'(meas_error);
      end
      S_DIV: begin
        u_a   = W'(div_a);
        u_b   = W'(sum_r);
        u_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      S_DIFF: begin
        u_a   = {{(W-DW){z_r[DW-1]}}, z_r};
        u_b   = {{(W-DW){est_r[DW-1]}}, est_r};
        u_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      S_NEG: begin
        u_b   = W'(md_r);
        u_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      S_MUL: begin
        u_a = {acc_r[W-2:0], 1'b0};
        u_b = mr_r[GAIN_BITS-1] ? W'(md_r) : '0;
      end
      S_CORR: begin
        // negative difference: est - q - (r != 0) as est + ~q + (r == 0); else est + q
        u_a   = {{(W-DW){est_r[DW-1]}}, est_r};
        u_b   = W'(acc_r[W-1:GAIN_BITS]);
        u_ctl = '{inv: neg_r, cin: neg_r & (acc_r[GAIN_BITS-1:0] == '0)};
      end
      S_H: begin
        u_b   = W'(q_r[GAIN_BITS-1:0]);
        u_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    z_nxt     = z_r;
    est_nxt   = est_r;
    err_nxt   = err_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    md_nxt    = md_r;
    mr_nxt    = mr_r;
    acc_nxt   = acc_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          z_nxt    = in_measurement;
          zero_nxt = 1'b0;
          if (in_restart_first) begin
            est_nxt = init_est;
            err_nxt = init_err;
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = u_y[DW:0];
        rem_nxt = (DW+2)'(err_r);
        q_nxt   = '0;
        cnt_nxt = '0;
        if (u_y[DW:0] == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring step: keep the difference when it did not borrow
        rem_nxt = u_cout ? u_y[DW+1:0] : div_a;
        q_nxt   = {q_r[GAIN_W-2:0], u_cout};
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_GCHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GCHK: begin
        if (q_r == '0) begin
          state_nxt = S_DONE;
        end else if (q_r == GAIN_ONE) begin
          est_nxt   = z_r;
          err_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        md_nxt  = u_y[DW:0];
        neg_nxt = u_y[DW];
        acc_nxt   = '0;
        mr_nxt    = q_r[GAIN_BITS-1:0];
        cnt_nxt   = '0;
        phase_nxt = 1'b0;
        state_nxt = u_y[DW] ? S_NEG : S_MUL;
      end
      S_NEG: begin
        md_nxt    = u_y[DW:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = u_y;
        mr_nxt  = {mr_r[GAIN_BITS-2:0], 1'b0};
        if (cnt_r == MUL_LAST) begin
          state_nxt = phase_r ? S_ERR : S_CORR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CORR: begin
        est_nxt   = u_y[DW-1:0];
        state_nxt = S_H;
      end
      S_H: begin
        // multiplier becomes one minus gain, multiplicand the old error
        mr_nxt    = u_y[GAIN_BITS-1:0];
        md_nxt    = (DW+1)'(err_r);
        acc_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = 1'b1;
        state_nxt = S_MUL;
      end
      S_ERR: begin
        err_nxt   = acc_r[GAIN_BITS +: DW];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      est_r       <= '0;
      err_r       <= FIXED_ONE;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      err_r       <= err_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    z_r    <= z_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    md_r   <= md_nxt;
    mr_r   <= mr_nxt;
    acc_r  <= acc_nxt;
    if (out_load) begin
      out_gain_r <= zero_r ? '0 : q_r;
      out_est_r  <= est_r;
      out_err_r  <= err_r;
      out_zero_r <= zero_r;
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_gain             = out_gain_r;
  assign out_new_estimate     = out_est_r;
  assign out_new_error        = out_err_r;
  assign out_zero_denominator = out_zero_r;

  // Assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("core took two transactions back to back");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain <= GAIN_ONE)
    else $error("gain above one");

  a_zero_den_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |-> out_gain == '0)
    else $error("zero denominator with nonzero gain");

  a_unit_gain_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gain == GAIN_ONE |-> out_new_error == '0)
    else $error("unit gain left a nonzero error");

endmodule
